### design/hfp_pkg.sv
// shared types and constants of the display link frame parser
package hfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HEAD_CMD  = 8'h55;
    localparam logic [BYTE_W-1:0] HEAD_DATA = 8'h70;
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h00;

    localparam logic [BYTE_W-1:0] CMD_FIRST  = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_SECOND = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_IDLE   = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_UNLOCK = 8'h05;

    localparam logic [LIMIT_W-1:0] LIMIT_CAP          = 7'd64;
    localparam logic [LIMIT_W-1:0] FIRST_LIMIT_RESET  = 7'd32;
    localparam logic [LIMIT_W-1:0] SECOND_LIMIT_RESET = 7'd64;
    localparam logic [LIMIT_W-1:0] MAX_RESULTS        = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LIMIT = 1'b1;

    localparam logic [KIND_W-1:0] EV_COMMAND     = 3'd0;
    localparam logic [KIND_W-1:0] EV_FIRST_BYTE  = 3'd1;
    localparam logic [KIND_W-1:0] EV_SECOND_BYTE = 3'd2;
    localparam logic [KIND_W-1:0] EV_FIRST_DONE  = 3'd3;
    localparam logic [KIND_W-1:0] EV_SECOND_DONE = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_SECOND = 2'd2
    } mode_t;

    typedef struct packed {
        logic push;
        logic drop;
        logic rd_en;
    } ring_ctrl_t;

endpackage

### design/hfp_ram.sv
// generic single write port ram with registered read
module hfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

### design/hfp_ring.sv
// ring buffer pointers, fill count and byte store
module hfp_ring #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hfp_pkg::ring_ctrl_t            ctrl,
    input  logic [hfp_pkg::BYTE_W-1:0]     wr_data,
    input  logic [$clog2(DEPTH+1):0]       drop_cnt,
    input  logic [$clog2(DEPTH+1):0]       rd_off,
    output logic [$clog2(DEPTH+1)-1:0]     fill,
    output logic [hfp_pkg::BYTE_W-1:0]     rd_data
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH+1);
    localparam int unsigned OFF_W = CNT_W + 1;
    localparam int unsigned SUM_W = OFF_W + 1;

    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             wr_en;
    logic [SUM_W-1:0] drop_sum, rd_sum;
    logic [PTR_W-1:0] rd_addr;

    assign fill  = fill_reg;
    assign wr_en = ctrl.push && (fill_reg != CNT_W'(DEPTH));

    always_comb begin
        rd_sum = SUM_W'(read_ptr_reg) + SUM_W'(rd_off);
        if (rd_sum >= SUM_W'(DEPTH)) begin
            rd_sum = rd_sum - SUM_W'(DEPTH);
        end
        rd_addr = rd_sum[PTR_W-1:0];
    end

    always_comb begin
        read_ptr_next  = read_ptr_reg;
        write_ptr_next = write_ptr_reg;
        fill_next      = fill_reg;
        drop_sum       = SUM_W'(read_ptr_reg) + SUM_W'(drop_cnt);
        if (drop_sum >= SUM_W'(DEPTH)) begin
            drop_sum = drop_sum - SUM_W'(DEPTH);
        end
        if (wr_en) begin
            write_ptr_next = (write_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : write_ptr_reg + 1'b1;
            fill_next      = fill_reg + 1'b1;
        end else if (ctrl.drop) begin
            if (drop_cnt >= OFF_W'(fill_reg)) begin
                read_ptr_next  = '0;
                write_ptr_next = '0;
                fill_next      = '0;
            end else begin
                read_ptr_next = drop_sum[PTR_W-1:0];
                fill_next     = fill_reg - drop_cnt[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_ptr_reg  <= '0;
            write_ptr_reg <= '0;
            fill_reg      <= '0;
        end else begin
            read_ptr_reg  <= read_ptr_next;
            write_ptr_reg <= write_ptr_next;
            fill_reg      <= fill_next;
        end
    end

    hfp_ram #(
        .WIDTH (hfp_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (write_ptr_reg),
        .wdata (wr_data),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );
endmodule

### design/hmi_frame_parser.sv
// frame parser for a serial display link: ring buffer plus byte-at-a-time scan sequencer
//
//  channel | ports                                   | dir | notes
//  input   | s_valid s_ready s_rx_byte               | in  | one received byte per item
//  result  | m_valid m_ready m_event_kind m_event_   | out | several results per item,
//          | value m_last m_unlock_level             |     | registered output
//  config  | cfg_we cfg_index cfg_data               | in  | field limits, idle only
//
// each item is written to the ring and the buffer is then scanned: a single ram read
// port delivers one held byte per cycle while no result stalls, and a waiting data
// frame is rescanned from its head on each new byte. s_ready is high only while the
// sequencer is idle. a stalled result holds the sequencer in place; the ram read is
// frozen meanwhile. reset is synchronous active low and clears pointers, mode and
// flags; the byte store needs no clearing since only held bytes are read.
module hmi_frame_parser #(
    parameter int unsigned BUFFER_DEPTH = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_event_kind,
    output logic [7:0]                        m_event_value,
    output logic                              m_last,
    output logic                              m_unlock_level,
    input  logic                              cfg_we,
    input  logic [hfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [6:0]                        cfg_data
);
    localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH+1);
    localparam int unsigned OFF_W = CNT_W + 1;
    localparam int unsigned CMP_W = (OFF_W > 7) ? OFF_W : 7;

    // one-hot sequencer states
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HEAD  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_CMD   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_PRIME = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [OFF_W-1:0]              off_reg, off_next;
    logic [1:0]                    run_reg, run_next;
    logic                          match_reg, match_next;
    logic [7:0]                    code_reg, code_next;
    logic [OFF_W-1:0]              len_reg, len_next;
    logic [OFF_W-1:0]              span_reg, span_next;
    hfp_pkg::mode_t                mode_reg, mode_next;
    logic                          taken_reg, taken_next;
    logic                          unlock_reg, unlock_next;
    logic [6:0]                    lim1_reg, lim2_reg;
    logic [6:0]                    emit_cnt_reg, emit_cnt_next;

    logic                          m_valid_reg;
    logic [2:0]                    kind_reg;
    logic [7:0]                    value_reg;
    logic                          last_reg;
    logic                          ulk_reg;

    // ring interface
    hfp_pkg::ring_ctrl_t           ring_ctrl;
    logic [OFF_W-1:0]              drop_cnt;
    logic [CNT_W-1:0]              fill;
    logic [7:0]                    rd_data;

    // result request from the sequencer
    logic                          want;
    logic [2:0]                    ev_kind;
    logic [7:0]                    ev_value;
    logic                          ev_last;
    logic                          ev_unlock;
    logic                          can_emit, out_free, fire, load_out;

    logic [6:0]                    lim_raw, lim_sat;
    logic [OFF_W-1:0]              scan_len;
    logic                          data_ok;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_event_kind   = kind_reg;
    assign m_event_value  = value_reg;
    assign m_last         = last_reg;
    assign m_unlock_level = ulk_reg;

    assign can_emit = (emit_cnt_reg < hfp_pkg::MAX_RESULTS);
    assign out_free = !m_valid_reg || m_ready;
    // a result over the per-item cap is skipped without stalling
    assign fire     = want && (!can_emit || out_free);
    assign load_out = want && can_emit && out_free;

    assign lim_raw  = (mode_reg == hfp_pkg::MODE_FIRST) ? lim1_reg : lim2_reg;
    assign lim_sat  = (lim_raw > hfp_pkg::LIMIT_CAP) ? hfp_pkg::LIMIT_CAP : lim_raw;
    assign scan_len = off_reg - OFF_W'(4);
    assign data_ok  = (mode_reg != hfp_pkg::MODE_IDLE) && !taken_reg;

    always_comb begin
        state_next    = state_reg;
        off_next      = off_reg;
        run_next      = run_reg;
        match_next    = match_reg;
        code_next     = code_reg;
        len_next      = len_reg;
        span_next     = span_reg;
        mode_next     = mode_reg;
        taken_next    = taken_reg;
        unlock_next   = unlock_reg;
        emit_cnt_next = emit_cnt_reg;
        ring_ctrl     = '0;
        drop_cnt      = '0;
        want          = 1'b0;
        ev_kind       = hfp_pkg::EV_COMMAND;
        ev_value      = code_reg;
        ev_last       = 1'b0;
        ev_unlock     = unlock_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ring_ctrl.push = 1'b1;
                    emit_cnt_next  = '0;
                    off_next       = '0;
                    state_next     = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (fill < CNT_W'(4)) begin
                    state_next = ST_IDLE;
                end else begin
                    ring_ctrl.rd_en = 1'b1;
                    off_next        = OFF_W'(1);
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // rd_data holds the head byte
                if (rd_data == hfp_pkg::HEAD_CMD) begin
                    if (fill < CNT_W'(7)) begin
                        state_next = ST_IDLE;
                    end else begin
                        ring_ctrl.rd_en = 1'b1;
                        off_next        = OFF_W'(2);
                        match_next      = 1'b1;
                        state_next      = ST_CMD;
                    end
                end else if (rd_data == hfp_pkg::HEAD_DATA && data_ok) begin
                    ring_ctrl.rd_en = 1'b1;
                    off_next        = OFF_W'(2);
                    run_next        = '0;
                    state_next      = ST_SCAN;
                end else begin
                    ring_ctrl.drop = 1'b1;
                    drop_cnt       = OFF_W'(1);
                    off_next       = '0;
                    state_next     = ST_HEAD;
                end
            end
            ST_CMD: begin
                // rd_data is byte off_reg-1 of the frame
                if (off_reg != OFF_W'(7)) begin
                    ring_ctrl.rd_en = 1'b1;
                    off_next        = off_reg + 1'b1;
                    if (off_reg == OFF_W'(2)) begin
                        code_next = rd_data;
                    end else if (off_reg == OFF_W'(3) || off_reg == OFF_W'(4)) begin
                        match_next = match_reg && (rd_data == hfp_pkg::PAD_BYTE);
                    end else begin
                        match_next = match_reg && (rd_data == hfp_pkg::TERM_BYTE);
                    end
                end else if (match_reg && rd_data == hfp_pkg::TERM_BYTE) begin
                    want      = 1'b1;
                    ev_kind   = hfp_pkg::EV_COMMAND;
                    ev_value  = code_reg;
                    ev_last   = 1'b1;
                    ev_unlock = unlock_reg || (code_reg == hfp_pkg::CMD_UNLOCK);
                    if (fire) begin
                        priority if (code_reg == hfp_pkg::CMD_FIRST) begin
                            mode_next  = hfp_pkg::MODE_FIRST;
                            taken_next = 1'b0;
                        end else if (code_reg == hfp_pkg::CMD_SECOND) begin
                            mode_next  = hfp_pkg::MODE_SECOND;
                            taken_next = 1'b0;
                        end else if (code_reg == hfp_pkg::CMD_IDLE) begin
                            mode_next  = hfp_pkg::MODE_IDLE;
                            taken_next = 1'b0;
                        end else if (code_reg == hfp_pkg::CMD_UNLOCK) begin
                            unlock_next = 1'b1;
                        end else begin
                            unlock_next = unlock_reg;
                        end
                        ring_ctrl.drop = 1'b1;
                        drop_cnt       = OFF_W'(7);
                        off_next       = '0;
                        state_next     = ST_HEAD;
                    end
                end else begin
                    ring_ctrl.drop = 1'b1;
                    drop_cnt       = OFF_W'(1);
                    off_next       = '0;
                    state_next     = ST_HEAD;
                end
            end
            ST_SCAN: begin
                // rd_data is byte off_reg-1; stop at the end of held bytes
                if (off_reg > OFF_W'(fill)) begin
                    state_next = ST_IDLE;
                end else if (rd_data == hfp_pkg::TERM_BYTE && run_reg == 2'd2) begin
                    // terminator ends at this byte: the frame spans off_reg bytes
                    if (CMP_W'(scan_len) < CMP_W'(lim_sat)) begin
                        len_next        = scan_len;
                        span_next       = off_reg;
                        ring_ctrl.rd_en = 1'b1;
                        off_next        = OFF_W'(1);
                        state_next      = ST_PRIME;
                    end else begin
                        ring_ctrl.drop = 1'b1;
                        drop_cnt       = off_reg;
                        off_next       = '0;
                        state_next     = ST_HEAD;
                    end
                end else begin
                    ring_ctrl.rd_en = 1'b1;
                    off_next        = off_reg + 1'b1;
                    run_next        = (rd_data == hfp_pkg::TERM_BYTE) ? run_reg + 1'b1 : 2'd0;
                end
            end
            ST_PRIME: begin
                ring_ctrl.rd_en = 1'b1;
                off_next        = OFF_W'(2);
                state_next      = ST_EMIT;
            end
            ST_EMIT: begin
                if (off_reg < len_reg + OFF_W'(2)) begin
                    want     = 1'b1;
                    ev_kind  = (mode_reg == hfp_pkg::MODE_FIRST) ?
                               hfp_pkg::EV_FIRST_BYTE : hfp_pkg::EV_SECOND_BYTE;
                    ev_value = rd_data;
                    if (fire) begin
                        ring_ctrl.rd_en = 1'b1;
                        off_next        = off_reg + 1'b1;
                    end
                end else begin
                    want     = 1'b1;
                    ev_kind  = (mode_reg == hfp_pkg::MODE_FIRST) ?
                               hfp_pkg::EV_FIRST_DONE : hfp_pkg::EV_SECOND_DONE;
                    ev_value = 8'(len_reg);
                    ev_last  = 1'b1;
                    if (fire) begin
                        taken_next     = 1'b1;
                        ring_ctrl.drop = 1'b1;
                        drop_cnt       = span_reg;
                        off_next       = '0;
                        state_next     = ST_HEAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fire && can_emit) begin
            emit_cnt_next = emit_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            off_reg      <= '0;
            run_reg      <= '0;
            match_reg    <= 1'b0;
            mode_reg     <= hfp_pkg::MODE_IDLE;
            taken_reg    <= 1'b0;
            unlock_reg   <= 1'b0;
            emit_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            lim1_reg     <= hfp_pkg::FIRST_LIMIT_RESET;
            lim2_reg     <= hfp_pkg::SECOND_LIMIT_RESET;
        end else begin
            state_reg    <= state_next;
            off_reg      <= off_next;
            run_reg      <= run_next;
            match_reg    <= match_next;
            mode_reg     <= mode_next;
            taken_reg    <= taken_next;
            unlock_reg   <= unlock_next;
            emit_cnt_reg <= emit_cnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // limit registers: the user writes them only while idle, not enforced here
            if (cfg_we) begin
                unique case (cfg_index)
                    hfp_pkg::CFG_FIRST_LIMIT:  lim1_reg <= cfg_data;
                    hfp_pkg::CFG_SECOND_LIMIT: lim2_reg <= cfg_data;
                    default: begin
                        lim1_reg <= lim1_reg;
                    end
                endcase
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        len_reg  <= len_next;
        span_reg <= span_next;
        if (load_out) begin
            kind_reg  <= ev_kind;
            value_reg <= ev_value;
            last_reg  <= ev_last;
            ulk_reg   <= ev_unlock;
        end
    end

    hfp_ring #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ring_ctrl),
        .wr_data  (s_rx_byte),
        .drop_cnt (drop_cnt),
        .rd_off   (off_reg),
        .fill     (fill),
        .rd_data  (rd_data)
    );
endmodule

### dv/hfp_checker.sv
// result checker for the display link frame parser: byte-level predictor and in-order compare
module hfp_checker #(
    parameter int unsigned DEPTH = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [2:0]                    m_event_kind,
    input  logic [7:0]                    m_event_value,
    input  logic                          m_last,
    input  logic                          m_unlock_level,
    input  logic                          cfg_we,
    input  logic [hfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]                    cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
        logic       unlock;
    } event_t;

    event_t          event_q[$];
    logic [7:0]      ring[DEPTH];
    int unsigned     rd_ptr, wr_ptr, held, frame_events;
    hfp_pkg::mode_t  mode;
    logic            taken, unlocked;
    logic [6:0]      first_limit, second_limit;

    function automatic logic [7:0] peek(int unsigned off);
        return ring[(rd_ptr + off) % DEPTH];
    endfunction

    function automatic void consume(int unsigned n);
        if (n >= held) begin
            rd_ptr = 0;
            wr_ptr = 0;
            held   = 0;
        end else begin
            rd_ptr = (rd_ptr + n) % DEPTH;
            held   = held - n;
        end
    endfunction

    // one item's run is capped at MAX_RESULTS events
    function automatic void push_event(logic [2:0] kind, logic [7:0] value, logic last);
        event_t ev;
        if (frame_events >= hfp_pkg::MAX_RESULTS) return;
        ev = '{kind: kind, value: value, last: last, unlock: unlocked};
        event_q.push_back(ev);
        frame_events++;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        logic [7:0]  code;
        int unsigned term, len, lim;
        frame_events = 0;
        if (held < DEPTH) begin
            ring[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            held++;
        end
        while (held >= 4) begin
            if (peek(0) == hfp_pkg::HEAD_CMD) begin
                if (held < 7) break;
                if (peek(2) == hfp_pkg::PAD_BYTE && peek(3) == hfp_pkg::PAD_BYTE &&
                    peek(4) == hfp_pkg::TERM_BYTE && peek(5) == hfp_pkg::TERM_BYTE &&
                    peek(6) == hfp_pkg::TERM_BYTE) begin
                    code = peek(1);
                    case (code)
                        hfp_pkg::CMD_FIRST: begin
                            mode  = hfp_pkg::MODE_FIRST;
                            taken = 1'b0;
                        end
                        hfp_pkg::CMD_SECOND: begin
                            mode  = hfp_pkg::MODE_SECOND;
                            taken = 1'b0;
                        end
                        hfp_pkg::CMD_IDLE: begin
                            mode  = hfp_pkg::MODE_IDLE;
                            taken = 1'b0;
                        end
                        hfp_pkg::CMD_UNLOCK: unlocked = 1'b1;
                        default: ;
                    endcase
                    push_event(hfp_pkg::EV_COMMAND, code, 1'b1);
                    consume(7);
                end else begin
                    consume(1);
                end
            end else if (peek(0) == hfp_pkg::HEAD_DATA && mode != hfp_pkg::MODE_IDLE &&
                         !taken) begin
                term = 0;
                for (int unsigned i = 1; i + 2 < held; i++) begin
                    if (peek(i) == hfp_pkg::TERM_BYTE && peek(i + 1) == hfp_pkg::TERM_BYTE &&
                        peek(i + 2) == hfp_pkg::TERM_BYTE) begin
                        term = i;
                        break;
                    end
                end
                // no terminator yet: keep waiting, even with the buffer full
                if (term == 0) break;
                len = term - 1;
                lim = (mode == hfp_pkg::MODE_FIRST) ? first_limit : second_limit;
                if (lim > hfp_pkg::LIMIT_CAP) lim = hfp_pkg::LIMIT_CAP;
                if (len < lim) begin
                    for (int unsigned i = 0; i < len; i++)
                        push_event(mode == hfp_pkg::MODE_FIRST ? hfp_pkg::EV_FIRST_BYTE
                                                               : hfp_pkg::EV_SECOND_BYTE,
                                   peek(i + 1), 1'b0);
                    push_event(mode == hfp_pkg::MODE_FIRST ? hfp_pkg::EV_FIRST_DONE
                                                           : hfp_pkg::EV_SECOND_DONE,
                               8'(len), 1'b1);
                    taken = 1'b1;
                end
                consume(term + 3);
            end else begin
                consume(1);
            end
        end
    endfunction

    always @(posedge aclk) begin
        event_t ev;
        if (!aresetn) begin
            event_q.delete();
            rd_ptr       = 0;
            wr_ptr       = 0;
            held         = 0;
            mode         = hfp_pkg::MODE_IDLE;
            taken        = 1'b0;
            unlocked     = 1'b0;
            first_limit  = hfp_pkg::FIRST_LIMIT_RESET;
            second_limit = hfp_pkg::SECOND_LIMIT_RESET;
            errors       = 0;
            checked      = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == hfp_pkg::CFG_FIRST_LIMIT) first_limit = cfg_data;
                else if (cfg_index == hfp_pkg::CFG_SECOND_LIMIT) second_limit = cfg_data;
            end
            if (m_valid && m_ready) begin
                checked++;
                if (event_q.size() == 0) begin
                    errors++;
                    $display("%t unexpected result: got kind %0d value %0h last %0b unlock %0b",
                             $realtime, m_event_kind, m_event_value, m_last, m_unlock_level);
                end else begin
                    ev = event_q.pop_front();
                    if (ev.kind !== m_event_kind || ev.value !== m_event_value ||
                        ev.last !== m_last || ev.unlock !== m_unlock_level) begin
                        errors++;
                        $display("%t result mismatch: expected kind %0d value %0h last %0b unlock %0b, got kind %0d value %0h last %0b unlock %0b",
                                 $realtime, ev.kind, ev.value, ev.last, ev.unlock,
                                 m_event_kind, m_event_value, m_last, m_unlock_level);
                    end
                end
            end
            if (s_valid && s_ready) take_byte(s_rx_byte);
        end
        pending = event_q.size();
    end
endmodule

### dv/tb_top.sv
// testbench top for the display link frame parser: stimulus, idling and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = 128;
    localparam int          DRAIN_WAIT = 400;      // worst rescan plus output slack
    localparam longint      CYCLE_CAP  = 3000000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_rx_byte = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [2:0]                    m_event_kind;
    logic [7:0]                    m_event_value;
    logic                          m_last;
    logic                          m_unlock_level;
    logic                          cfg_we = 1'b0;
    logic [hfp_pkg::CFG_IDX_W-1:0] cfg_index = hfp_pkg::CFG_FIRST_LIMIT;
    logic [6:0]                    cfg_data = '0;

    int     errors, pending, checked;
    int     bytes_sent = 0;
    bit     calm = 1'b0;          // no idling on either side in the final stretch
    longint cycles = 0;

    hmi_frame_parser #(.BUFFER_DEPTH(DEPTH)) dut (.*);

    hfp_checker #(.DEPTH(DEPTH)) chk (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // runaway guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        int stall;
        if (stall > 0) begin
            stall--;
            if (stall == 0) m_ready <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // offer one byte; returns in the step where it was taken, s_valid still high
    task automatic send_byte(logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic send_command(logic [7:0] code);
        send_byte(hfp_pkg::HEAD_CMD);
        send_byte(code);
        send_byte(hfp_pkg::PAD_BYTE);
        send_byte(hfp_pkg::PAD_BYTE);
        repeat (3) send_byte(hfp_pkg::TERM_BYTE);
    endtask

    // data frame with random payload; a run of terminators inside ends it early
    task automatic send_data(int unsigned len);
        send_byte(hfp_pkg::HEAD_DATA);
        repeat (len) send_byte($urandom_range(0, 3) == 0 ? hfp_pkg::TERM_BYTE : 8'($urandom));
        repeat (3) send_byte(hfp_pkg::TERM_BYTE);
    endtask

    // limits only change with the parser drained and settled
    task automatic set_limits(logic [6:0] first, logic [6:0] second);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= hfp_pkg::CFG_FIRST_LIMIT;
        cfg_data  <= first;
        @(posedge aclk);
        cfg_index <= hfp_pkg::CFG_SECOND_LIMIT;
        cfg_data  <= second;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(int unsigned n_bytes);
        int unsigned stop, pick;
        logic [7:0]  codes[5];
        codes = '{hfp_pkg::CMD_FIRST, hfp_pkg::CMD_SECOND, hfp_pkg::CMD_IDLE,
                  hfp_pkg::CMD_UNLOCK, 8'h00};
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                codes[4] = 8'($urandom);
                send_command(codes[$urandom_range(0, 4)]);
            end else if (pick < 80) begin
                // mostly short frames, now and then one around the cap
                send_data($urandom_range(0, 19) == 0 ? $urandom_range(60, 70)
                                                     : $urandom_range(0, 10));
            end else if (pick < 90) begin
                // broken command: bad padding or cut short
                send_byte(hfp_pkg::HEAD_CMD);
                send_byte(8'($urandom));
                send_byte(8'($urandom_range(0, 1)));
                send_byte($urandom_range(0, 1) ? hfp_pkg::TERM_BYTE : 8'($urandom));
            end else begin
                send_byte($urandom_range(0, 1) ? hfp_pkg::HEAD_DATA : 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default limits first, then unlock, both modes, payload extremes
        send_command(hfp_pkg::CMD_UNLOCK);
        send_command(hfp_pkg::CMD_FIRST);
        send_byte(hfp_pkg::HEAD_DATA);
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(8'h80);
        send_byte(8'h7F);
        repeat (3) send_byte(hfp_pkg::TERM_BYTE);
        send_command(hfp_pkg::CMD_SECOND);

        // limits from the bottom to the top and past the cap
        set_limits(7'd1, 7'd64);
        random_traffic(80);
        set_limits(7'd64, 7'd1);
        random_traffic(80);
        set_limits(7'd0, 7'd127);
        random_traffic(70);
        set_limits(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
        calm = 1'b1;
        random_traffic(50);

        // unterminated frame fills the buffer; later bytes are dropped
        send_command(hfp_pkg::CMD_FIRST);
        send_byte(hfp_pkg::HEAD_DATA);
        repeat (DEPTH + 8) send_byte(8'($urandom_range(0, 254)));

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d bytes in, %0d events compared across five limit settings,",
                 bytes_sent, checked);
        $display("including over-cap frames, broken commands and a full buffer");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

### sim.f
design/hfp_pkg.sv
design/hfp_ram.sv
design/hfp_ring.sv
design/hmi_frame_parser.sv
dv/hfp_checker.sv
dv/tb_top.sv
